FILE: hdl/rwr_pkg.sv
// ----------------------------------------------------------------------------
// Repeated word remover package
// Shared types, constants and helpers for the repeated word remover blocks.
// ----------------------------------------------------------------------------
package rwr_pkg;

    localparam int MAX_WORD_DEF  = 32;
    localparam int MAX_SPACE_DEF = 16;
    localparam int CMD_DEPTH     = 4;
    localparam int OUT_DEPTH     = 2;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    typedef enum logic [1:0] {
        CMD_TEXT,
        CMD_SPACE,
        CMD_NEWLINE,
        CMD_EOF
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       space_dropped;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPACE_RD,
        S_SPACE_WR,
        S_WORD_RD,
        S_WORD_WR,
        S_FINISH_WORD,
        S_CMP_RD,
        S_CMP,
        S_EMIT_C,
        S_NL
    } back_state_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

FILE: hdl/repeated_word_remover_unit.sv
// ----------------------------------------------------------------------------
// Repeated word remover unit
// Filters a text stream, dropping each word that equals the word before it.
// ----------------------------------------------------------------------------
// Path: an accepted word passes the command queue, the back end state machine
// and the output queue before its first result word is on the result ports.
// Flow: a byte inside a word passes S_IDLE and S_CMP, whitespace outside a word
// S_IDLE only; each buffered byte sent out passes a read and a write state, set
// by the single registered read port of the word and whitespace memories.
// Reset: asynchronous, clears all control state; the buffers need no clearing.
module repeated_word_remover_unit
    import rwr_pkg::*;
#(
    parameter int MAX_WORD  = MAX_WORD_DEF,
    parameter int MAX_SPACE = MAX_SPACE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    cmd_t                         cmd;
    logic                         cmd_empty;
    logic                         cmd_pop;
    logic                         out_full;
    logic                         out_push;
    out_item_t                    out_word;
    logic [$bits(out_item_t)-1:0] result_bits;

    rwr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop)
    );

    rwr_back #(
        .MAX_WORD  (MAX_WORD),
        .MAX_SPACE (MAX_SPACE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_word  (out_word)
    );

    rwr_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_word),
        .full    (out_full),
        .pop     (pop),
        .rd_data (result_bits),
        .empty   (empty)
    );

    assign result = out_item_t'(result_bits);

    // The back end only writes a result word when the output queue has room.
    assert property (@(posedge clk) disable iff (!rst_n) out_push |-> !out_full)
        else $error("result written into a full output queue");

    // A newline always closes the run of its input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.out_byte == CHAR_NEWLINE)) |-> result.last)
        else $error("newline result not marked as last");

    // The dropped whitespace flag never clears on later results.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && result.space_dropped) |=> (empty || result.space_dropped))
        else $error("dropped whitespace flag cleared");

endmodule

FILE: hdl/rwr_fifo.sv
// ----------------------------------------------------------------------------
// Repeated word remover queue
// Small show-ahead queue with a push/full side and a pop/empty side.
// ----------------------------------------------------------------------------
module rwr_fifo
    import rwr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = CMD_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/rwr_front.sv
// ----------------------------------------------------------------------------
// Repeated word remover front end
// Accepts input words, classifies each byte and queues a command for the back end.
// ----------------------------------------------------------------------------
module rwr_front
    import rwr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    output cmd_t     cmd,
    output logic     cmd_empty,
    input  logic     cmd_pop
);

    cmd_t                 cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    always_comb
    begin
        cmd_in.ch = item.char_byte;
        if (item.opcode == OP_EOF)
        begin
            cmd_in.kind = CMD_EOF;
        end
        else if (item.char_byte == CHAR_NEWLINE)
        begin
            cmd_in.kind = CMD_NEWLINE;
        end
        else if (is_space(item.char_byte))
        begin
            cmd_in.kind = CMD_SPACE;
        end
        else
        begin
            cmd_in.kind = CMD_TEXT;
        end
    end

    rwr_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_bits),
        .empty   (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_bits);

endmodule

FILE: hdl/rwr_back.sv
// ----------------------------------------------------------------------------
// Repeated word remover back end
// Buffers words and held whitespace, matches each word against the previous
// one and emits the filtered text one word at a time.
// ----------------------------------------------------------------------------
module rwr_back
    import rwr_pkg::*;
#(
    parameter int MAX_WORD  = MAX_WORD_DEF,
    parameter int MAX_SPACE = MAX_SPACE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    input  logic      out_full,
    output logic      out_push,
    output out_item_t out_word
);

    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int SW = $clog2(MAX_SPACE + 1);
    localparam int IW = (LW > SW) ? LW : SW;
    localparam int WA = $clog2(2 * MAX_WORD);
    localparam int SA = (MAX_SPACE > 1) ? $clog2(MAX_SPACE) : 1;

    back_state_t   state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          cur_bank_reg, cur_bank_next;
    logic [LW-1:0] cur_len_reg, cur_len_next;
    logic [LW-1:0] prev_len_reg, prev_len_next;
    logic          prev_valid_reg, prev_valid_next;
    logic          still_match_reg, still_match_next;
    logic          too_long_reg, too_long_next;
    logic [SW-1:0] space_cnt_reg, space_cnt_next;
    logic          line_has_word_reg, line_has_word_next;
    logic          in_word_reg, in_word_next;
    logic          line_open_reg, line_open_next;
    logic          dropped_reg, dropped_next;

    logic [7:0]    word_mem [2 * MAX_WORD];
    logic [7:0]    space_mem [MAX_SPACE];
    logic [7:0]    word_rd_reg;
    logic [7:0]    space_rd_reg;

    logic [WA-1:0] cur_base;
    logic [WA-1:0] prev_base;
    logic [WA-1:0] word_rd_addr;
    logic          word_wr_en;
    logic [WA-1:0] word_wr_addr;
    logic [SA-1:0] space_rd_addr;
    logic          space_wr_en;
    logic [SA-1:0] space_wr_addr;
    logic [7:0]    space_wr_data;
    logic          dup;
    logic          space_full;
    logic          word_full;
    logic          idx_done_word;
    logic          idx_done_space;
    logic          do_store_space;
    logic          do_line_end;

    assign cur_base       = cur_bank_reg ? WA'(MAX_WORD) : '0;
    assign prev_base      = cur_bank_reg ? '0 : WA'(MAX_WORD);
    assign dup            = prev_valid_reg && still_match_reg && (cur_len_reg == prev_len_reg);
    assign space_full     = (space_cnt_reg == SW'(MAX_SPACE));
    assign word_full      = (cur_len_reg == LW'(MAX_WORD));
    assign idx_done_word  = ((idx_reg + IW'(1)) == IW'(cur_len_reg));
    assign idx_done_space = ((idx_reg + IW'(1)) == IW'(space_cnt_reg));
    assign space_rd_addr  = SA'(idx_reg);

    always_comb
    begin
        if ((state_reg == S_WORD_RD) || (state_reg == S_WORD_WR))
        begin
            word_rd_addr = cur_base + WA'(idx_reg);
        end
        else
        begin
            word_rd_addr = prev_base + (in_word_reg ? WA'(cur_len_reg) : '0);
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        idx_next           = idx_reg;
        cur_bank_next      = cur_bank_reg;
        cur_len_next       = cur_len_reg;
        prev_len_next      = prev_len_reg;
        prev_valid_next    = prev_valid_reg;
        still_match_next   = still_match_reg;
        too_long_next      = too_long_reg;
        space_cnt_next     = space_cnt_reg;
        line_has_word_next = line_has_word_reg;
        in_word_next       = in_word_reg;
        line_open_next     = line_open_reg;
        dropped_next       = dropped_reg;
        cmd_pop            = 1'b0;
        out_push           = 1'b0;
        out_word.out_byte  = '0;
        out_word.last      = 1'b0;
        out_word.space_dropped = dropped_reg;
        word_wr_en         = 1'b0;
        word_wr_addr       = cur_base + WA'(cur_len_reg);
        space_wr_data      = cmd_reg.ch;
        do_store_space     = 1'b0;
        do_line_end        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                space_wr_data = cmd.ch;
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    idx_next = '0;
                    unique case (cmd.kind)
                        CMD_EOF:
                        begin
                            if (line_open_reg)
                            begin
                                do_line_end = 1'b1;
                            end
                            else
                            begin
                                prev_valid_next  = 1'b0;
                                still_match_next = 1'b0;
                            end
                        end
                        CMD_NEWLINE:
                        begin
                            do_line_end = 1'b1;
                        end
                        CMD_SPACE:
                        begin
                            if (space_full)
                            begin
                                dropped_next = 1'b1;
                            end
                            if (in_word_reg)
                            begin
                                state_next = (too_long_reg || dup) ? S_FINISH_WORD : S_WORD_RD;
                            end
                            else
                            begin
                                do_store_space = 1'b1;
                            end
                        end
                        CMD_TEXT:
                        begin
                            line_open_next = 1'b1;
                            if (!in_word_reg)
                            begin
                                in_word_next       = 1'b1;
                                line_has_word_next = 1'b1;
                                cur_len_next       = '0;
                                too_long_next      = 1'b0;
                                still_match_next   = prev_valid_reg;
                                state_next = (space_cnt_reg != '0) ? S_SPACE_RD : S_CMP;
                            end
                            else if (too_long_reg)
                            begin
                                state_next = S_EMIT_C;
                            end
                            else if (word_full)
                            begin
                                state_next = S_WORD_RD;
                            end
                            else
                            begin
                                state_next = S_CMP;
                            end
                        end
                    endcase
                    if (do_line_end)
                    begin
                        if (in_word_reg)
                        begin
                            state_next = (too_long_reg || dup) ? S_FINISH_WORD : S_WORD_RD;
                        end
                        else if (!line_has_word_reg && (space_cnt_reg != '0))
                        begin
                            state_next = S_SPACE_RD;
                        end
                        else
                        begin
                            state_next = S_NL;
                        end
                    end
                end
            end
            S_SPACE_RD:
            begin
                state_next = S_SPACE_WR;
            end
            S_SPACE_WR:
            begin
                if (!out_full)
                begin
                    out_push          = 1'b1;
                    out_word.out_byte = space_rd_reg;
                    out_word.last     = idx_done_space && (cmd_reg.kind == CMD_TEXT);
                    if (idx_done_space)
                    begin
                        space_cnt_next = '0;
                        state_next = (cmd_reg.kind == CMD_TEXT) ? S_CMP_RD : S_NL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_SPACE_RD;
                    end
                end
            end
            S_WORD_RD:
            begin
                state_next = S_WORD_WR;
            end
            S_WORD_WR:
            begin
                if (!out_full)
                begin
                    out_push          = 1'b1;
                    out_word.out_byte = word_rd_reg;
                    out_word.last     = idx_done_word && (cmd_reg.kind == CMD_SPACE);
                    if (idx_done_word)
                    begin
                        if (cmd_reg.kind == CMD_TEXT)
                        begin
                            too_long_next = 1'b1;
                            state_next    = S_EMIT_C;
                        end
                        else
                        begin
                            state_next = S_FINISH_WORD;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_WORD_RD;
                    end
                end
            end
            S_FINISH_WORD:
            begin
                if (too_long_reg)
                begin
                    prev_valid_next = 1'b0;
                end
                else
                begin
                    prev_len_next   = cur_len_reg;
                    prev_valid_next = 1'b1;
                    cur_bank_next   = !cur_bank_reg;
                end
                in_word_next  = 1'b0;
                too_long_next = 1'b0;
                cur_len_next  = '0;
                if (cmd_reg.kind == CMD_SPACE)
                begin
                    do_store_space = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_NL;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if ((cur_len_reg >= prev_len_reg) || (word_rd_reg != cmd_reg.ch))
                begin
                    still_match_next = 1'b0;
                end
                word_wr_en   = 1'b1;
                cur_len_next = cur_len_reg + LW'(1);
                state_next   = S_IDLE;
            end
            S_EMIT_C:
            begin
                if (!out_full)
                begin
                    out_push          = 1'b1;
                    out_word.out_byte = cmd_reg.ch;
                    out_word.last     = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_NL:
            begin
                if (!out_full)
                begin
                    out_push           = 1'b1;
                    out_word.out_byte  = CHAR_NEWLINE;
                    out_word.last      = 1'b1;
                    space_cnt_next     = '0;
                    line_has_word_next = 1'b0;
                    line_open_next     = 1'b0;
                    if (cmd_reg.kind == CMD_EOF)
                    begin
                        prev_valid_next  = 1'b0;
                        still_match_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        space_wr_en   = do_store_space && !space_full;
        space_wr_addr = SA'(space_cnt_reg);
        if (do_store_space)
        begin
            line_open_next = 1'b1;
            if (!space_full)
            begin
                space_cnt_next = space_cnt_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            idx_reg           <= '0;
            cur_bank_reg      <= 1'b0;
            cur_len_reg       <= '0;
            prev_len_reg      <= '0;
            prev_valid_reg    <= 1'b0;
            still_match_reg   <= 1'b0;
            too_long_reg      <= 1'b0;
            space_cnt_reg     <= '0;
            line_has_word_reg <= 1'b0;
            in_word_reg       <= 1'b0;
            line_open_reg     <= 1'b0;
            dropped_reg       <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            idx_reg           <= idx_next;
            cur_bank_reg      <= cur_bank_next;
            cur_len_reg       <= cur_len_next;
            prev_len_reg      <= prev_len_next;
            prev_valid_reg    <= prev_valid_next;
            still_match_reg   <= still_match_next;
            too_long_reg      <= too_long_next;
            space_cnt_reg     <= space_cnt_next;
            line_has_word_reg <= line_has_word_next;
            in_word_reg       <= in_word_next;
            line_open_reg     <= line_open_next;
            dropped_reg       <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk)
    begin
        if (word_wr_en)
        begin
            word_mem[word_wr_addr] <= cmd_reg.ch;
        end
        word_rd_reg <= word_mem[word_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (space_wr_en)
        begin
            space_mem[space_wr_addr] <= space_wr_data;
        end
        space_rd_reg <= space_mem[space_rd_addr];
    end

endmodule
